>>> hdl/order_book_snapshot_aggregator_macros.svh
// Assertion helpers, clocked on clk_i, held off during reset.
`ifndef ORDER_BOOK_SNAPSHOT_AGGREGATOR_MACROS_SVH
`define ORDER_BOOK_SNAPSHOT_AGGREGATOR_MACROS_SVH

// same-cycle implication
`define OBSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define OBSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/obsa_pkg.sv
package obsa_pkg;

  localparam int unsigned PW = 47;  // price / quantity magnitude
  localparam int unsigned DW = 53;  // per-side depth

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_NEG_PRICE = 3'd1;
  localparam logic [2:0] STATUS_NEG_QTY  = 3'd2;
  localparam logic [2:0] STATUS_QTY_OVF  = 3'd3;
  localparam logic [2:0] STATUS_FULL     = 3'd4;

  localparam logic SIDE_BID = 1'b0;

  // compare / add result handed to the sequencer
  typedef struct packed {
    logic          eq;      // entry price equals request price
    logic          beyond;  // request belongs before this entry
    logic          ovf;     // merged quantity exceeds 2^47-1
    logic [PW-1:0] sum;     // merged quantity
  } cmp_t;

endpackage

>>> hdl/obsa_ram.sv
module obsa_ram #(
  parameter int unsigned WIDTH = 94,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/obsa_alu.sv
module obsa_alu
  import obsa_pkg::*;
(
  input  logic          descend_i,
  input  logic [PW-1:0] price_i,
  input  logic [PW-1:0] qty_i,
  input  logic [PW-1:0] ent_price_i,
  input  logic [PW-1:0] ent_qty_i,
  output cmp_t          cmp_o
);

  logic [PW:0] sum;

  assign sum = {1'b0, qty_i} + {1'b0, ent_qty_i};

  always_comb begin
    cmp_o.eq     = (ent_price_i == price_i);
    cmp_o.beyond = descend_i ? (ent_price_i < price_i) : (ent_price_i > price_i);
    cmp_o.ovf    = sum[PW];
    cmp_o.sum    = sum[PW-1:0];
  end

endmodule

>>> hdl/order_book_snapshot_aggregator.sv
// Channel  | Dir | Signals                        | Contents
// s_axis   | in  | tvalid/tready/tdata[103:0]/tlast | one price level, tlast = last level
// m_axis   | out | tvalid/tready/tdata[447:0]/tuser | book summary, tuser = status
//
// An item that is skipped or follows an error goes from its check step to the
// closing step; otherwise a search pass and a shift pass walk the levels staged
// on that side, a read and a compare or write step per entry, over the table
// RAM (one read, one write port). A last item adds an output step to load the
// result register; the commit rides on the closing step every item has.
// Reset (rst_ni low, asynchronous) empties book and staged tables; table RAM
// contents are not cleared, counts alone define what is valid.
// s_axis_tready_o is high only while idle; a pending result stalls a later
// last item in its output step, never a non-last item.
`include "order_book_snapshot_aggregator_macros.svh"

module order_book_snapshot_aggregator
  import obsa_pkg::*;
#(
  parameter int unsigned LEVELS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // side[0], level_price[48:1], level_quantity[96:49], zero pad
  input  logic [103:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,   // last_level
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // bid_valid[0], best_bid_price[47:1], best_bid_qty[94:48], ask_valid[95],
  // best_ask_price[142:96], best_ask_qty[189:143], spread[237:190],
  // mid_price[284:238], bid_sum[337:285], ask_sum[390:338],
  // book_sum[444:391], zero pad
  output logic [447:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]   m_axis_tuser_o
);

  localparam int unsigned IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;  // entry index
  localparam int unsigned CW = $clog2(LEVELS + 1);                 // count
  localparam int unsigned RD = 2 ** (IW + 1);                      // both sides
  localparam logic [CW-1:0] CNT_MAX = CW'(LEVELS);
  localparam logic [DW-1:0] DEPTH_SAT = {DW{1'b1}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_INS   = 4'd4;
  localparam logic [3:0] S_SHR   = 4'd5;
  localparam logic [3:0] S_SHW   = 4'd6;
  localparam logic [3:0] S_END   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [2:0]    err_q, err_d;
  logic [2:0]    rep_q, rep_d;

  // latched request
  logic          side_q;
  logic [PW-1:0] price_q, qty_q;
  logic          pneg_q, qneg_q, last_q;

  logic [CW-1:0] pos_q, pos_d, k_q, k_d;

  // staged summary per side
  logic [CW-1:0] st_cnt_q   [2];
  logic [PW-1:0] st_bprc_q  [2];
  logic [PW-1:0] st_bqty_q  [2];
  logic [DW-1:0] st_depth_q [2];
  // committed book summary per side
  logic [CW-1:0] bk_cnt_q   [2];
  logic [PW-1:0] bk_bprc_q  [2];
  logic [PW-1:0] bk_bqty_q  [2];
  logic [DW-1:0] bk_depth_q [2];

  logic          out_valid_q;
  logic [447:0]  out_data_q;
  logic [2:0]    out_user_q;

  // table RAM
  logic              ram_we;
  logic [IW:0]       ram_waddr, ram_raddr;
  logic [2*PW-1:0]   ram_wdata, ram_rdata;
  logic [PW-1:0]     ent_price, ent_qty;

  cmp_t          cmp;
  logic [CW-1:0] n_cur, km1;
  logic [DW:0]   depth_sum;
  logic [DW-1:0] depth_new;
  logic          out_free;
  logic          walking;

  assign ent_price = ram_rdata[PW-1:0];
  assign ent_qty   = ram_rdata[2*PW-1:PW];
  assign n_cur     = st_cnt_q[side_q];
  assign km1       = k_q - CW'(1);
  assign depth_sum = {1'b0, st_depth_q[side_q]} + (DW + 1)'(qty_q);
  assign depth_new = depth_sum[DW] ? DEPTH_SAT : depth_sum[DW-1:0];
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign walking   = (state_q == S_SRD) || (state_q == S_SCMP) ||
                     (state_q == S_SHR) || (state_q == S_SHW);

  obsa_ram #(
    .WIDTH (2 * PW),
    .DEPTH (RD)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  obsa_alu u_alu (
    .descend_i   (side_q == SIDE_BID),
    .price_i     (price_q),
    .qty_i       (qty_q),
    .ent_price_i (ent_price),
    .ent_qty_i   (ent_qty),
    .cmp_o       (cmp)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    err_d     = err_q;
    rep_d     = rep_q;
    pos_d     = pos_q;
    k_d       = k_q;
    ram_we    = 1'b0;
    ram_waddr = {side_q, pos_q[IW-1:0]};
    ram_wdata = {qty_q, price_q};
    ram_raddr = {side_q, pos_q[IW-1:0]};
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_END;
        if (err_q == STATUS_OK) begin
          if (pneg_q) begin
            err_d = STATUS_NEG_PRICE;
          end else if (qneg_q) begin
            err_d = STATUS_NEG_QTY;
          end else if (qty_q != '0) begin
            pos_d   = '0;
            state_d = S_SRD;
          end
        end
      end
      S_SRD: begin
        state_d = (pos_q == n_cur) ? S_INS : S_SCMP;
      end
      S_SCMP: begin
        if (cmp.eq) begin
          state_d = S_END;
          if (cmp.ovf) begin
            err_d = STATUS_QTY_OVF;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {cmp.sum, price_q};
          end
        end else if (cmp.beyond) begin
          state_d = S_INS;
        end else begin
          pos_d   = pos_q + CW'(1);
          state_d = S_SRD;
        end
      end
      S_INS: begin
        if (n_cur == CNT_MAX) begin
          err_d   = STATUS_FULL;
          state_d = S_END;
        end else begin
          k_d     = n_cur;
          state_d = S_SHR;
        end
      end
      S_SHR: begin
        if (k_q == pos_q) begin
          ram_we  = 1'b1;
          state_d = S_END;
        end else begin
          ram_raddr = {side_q, km1[IW-1:0]};
          state_d   = S_SHW;
        end
      end
      S_SHW: begin
        ram_we    = 1'b1;
        ram_waddr = {side_q, k_q[IW-1:0]};
        ram_wdata = ram_rdata;
        k_d       = km1;
        state_d   = S_SHR;
      end
      S_END: begin
        if (last_q) begin
          rep_d   = err_q;
          err_d   = STATUS_OK;
          state_d = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= STATUS_OK;
      rep_q   <= STATUS_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      rep_q   <= rep_d;
    end
  end

  // request latch and walk pointers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid_i) begin
      side_q  <= s_axis_tdata_i[0];
      price_q <= s_axis_tdata_i[PW:1];
      pneg_q  <= s_axis_tdata_i[48];
      qty_q   <= s_axis_tdata_i[PW+48:49];
      qneg_q  <= s_axis_tdata_i[96];
      last_q  <= s_axis_tlast_i;
    end
    pos_q <= pos_d;
    k_q   <= k_d;
  end

  // staged and book summaries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        st_cnt_q[s]   <= '0;
        st_depth_q[s] <= '0;
        bk_cnt_q[s]   <= '0;
        bk_depth_q[s] <= '0;
      end
    end else begin
      if (state_q == S_SCMP && cmp.eq && !cmp.ovf) begin
        st_depth_q[side_q] <= depth_new;
      end
      if (state_q == S_SHR && k_q == pos_q) begin
        st_depth_q[side_q] <= depth_new;
        st_cnt_q[side_q]   <= n_cur + CW'(1);
      end
      if (state_q == S_END && last_q) begin
        for (int s = 0; s < 2; s++) begin
          if (err_q == STATUS_OK) begin
            bk_cnt_q[s]   <= st_cnt_q[s];
            bk_depth_q[s] <= st_depth_q[s];
          end
          st_cnt_q[s]   <= '0;
          st_depth_q[s] <= '0;
        end
      end
    end
  end

  // best level is entry zero; valid whenever its count is non-zero
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCMP && cmp.eq && !cmp.ovf && pos_q == '0) begin
      st_bqty_q[side_q] <= cmp.sum;
    end
    if (state_q == S_SHR && k_q == pos_q && pos_q == '0) begin
      st_bprc_q[side_q] <= price_q;
      st_bqty_q[side_q] <= qty_q;
    end
    if (state_q == S_END && last_q && err_q == STATUS_OK) begin
      for (int s = 0; s < 2; s++) begin
        bk_bprc_q[s] <= st_bprc_q[s];
        bk_bqty_q[s] <= st_bqty_q[s];
      end
    end
  end

  // result assembly
  logic          bv, av;
  logic [PW-1:0] bbp, bbq, bap, baq, mid;
  logic [PW:0]   spread, half, msum;

  always_comb begin
    bv     = (bk_cnt_q[0] != '0);
    av     = (bk_cnt_q[1] != '0);
    bbp    = bv ? bk_bprc_q[0] : '0;
    bbq    = bv ? bk_bqty_q[0] : '0;
    bap    = av ? bk_bprc_q[1] : '0;
    baq    = av ? bk_bqty_q[1] : '0;
    spread = (bv && av) ? ({1'b0, bap} - {1'b0, bbp}) : '0;
    // divide by two, rounding toward zero
    half   = $signed(spread + (PW + 1)'(spread[PW])) >>> 1;
    msum   = {1'b0, bbp} + half;
    mid    = (bv && av) ? msum[PW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_user_q <= rep_q;
      out_data_q <= {3'b000,
                     (DW + 1)'(bk_depth_q[0]) + (DW + 1)'(bk_depth_q[1]),
                     bk_depth_q[1], bk_depth_q[0], mid, spread,
                     baq, bap, av, bbq, bbp, bv};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `OBSA_ASSERT_IMP(a_cnt_bound, 1'b1, st_cnt_q[0] <= CNT_MAX && st_cnt_q[1] <= CNT_MAX)
  `OBSA_ASSERT_IMP(a_walk_no_err, walking, err_q == STATUS_OK)
  `OBSA_ASSERT_NXT(a_out_load, state_q == S_OUT && out_free, m_axis_tvalid_o && state_q == S_IDLE)
  `OBSA_ASSERT_IMP(a_shift_range, state_q == S_SHR, k_q >= pos_q && k_q <= n_cur)

endmodule
